[rtl/ukolt_pkg.sv]
package ukolt_pkg;

   // Default table depth
   localparam int CAPACITY_DEF = 64;

   // Field widths
   localparam int CMD_W      = 2;
   localparam int KEY_W      = 32;
   localparam int TAG_W      = 32;
   localparam int WEIGHT_W   = 24;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 7;
   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 8;

   // Command codes
   typedef enum logic [CMD_W-1:0] {
      OP_INS_TAIL = 2'd0,
      OP_INS_HEAD = 2'd1,
      OP_FIND     = 2'd2,
      OP_REMOVE   = 2'd3
   } op_type;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_DONE    = 2'd0,
      ST_DUP     = 2'd1,
      ST_MISSING = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   // Controller to datapath commands
   typedef struct packed {
      logic       capture;
      logic       walk_head;
      logic       walk_next;
      logic       link_new;
      logic       link_nbr;
      logic       unlink;
      logic       status_load;
      status_type status_code;
      logic       rsp_load;
   } ctl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      op_type op;
      logic   list_empty;
      logic   key_hit;
      logic   next_null;
      logic   table_full;
      logic   out_free;
   } dp_stat_type;

endpackage

[rtl/ukolt_datapath.sv]
module ukolt_datapath #(
   parameter int CAPACITY = ukolt_pkg::CAPACITY_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [ukolt_pkg::REQ_DATA_W-1:0]  req_data,
   input  logic [ukolt_pkg::CMD_W-1:0]       req_user,
   input  ukolt_pkg::ctl_cmd_type            ctl,
   output ukolt_pkg::dp_stat_type            stat,
   input  logic                              rsp_tready,
   output logic                              rsp_tvalid,
   output logic [ukolt_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic [ukolt_pkg::STATUS_W-1:0]    rsp_tuser
);
   import ukolt_pkg::*;

   localparam int SLOT_W = $clog2(CAPACITY);
   localparam int IDX_W  = $clog2(CAPACITY + 1);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam logic [IDX_W-1:0] NIL = IDX_W'(CAPACITY);

   // Entry stores and link memories
   logic [KEY_W-1:0]    key_mem  [CAPACITY];
   logic [TAG_W-1:0]    tag_mem  [CAPACITY];
   logic [WEIGHT_W-1:0] wgt_mem  [CAPACITY];
   logic [IDX_W-1:0]    nxt_mem  [CAPACITY];
   logic [IDX_W-1:0]    prv_mem  [CAPACITY];
   logic [SLOT_W-1:0]   free_mem [CAPACITY];

   // Command fields held for the item in work
   op_type              op_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [TAG_W-1:0]    tag_ff;
   logic [WEIGHT_W-1:0] weight_ff;

   // Walk read port
   logic [IDX_W-1:0]    cur_ff;
   logic [KEY_W-1:0]    key_rd_ff;
   logic [IDX_W-1:0]    next_rd_ff;
   logic [IDX_W-1:0]    prev_rd_ff;
   logic [SLOT_W-1:0]   free_rd_ff;

   // List control
   logic [IDX_W-1:0]    head_ff, head_in;
   logic [IDX_W-1:0]    tail_ff, tail_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    fsp_ff, fsp_in;
   logic [CNT_W-1:0]    hwm_ff, hwm_in;
   logic [SLOT_W-1:0]   slot_ff;
   status_type          status_ff;

   // Result register
   logic                rsp_valid_ff;
   status_type          rsp_status_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;

   logic [IDX_W-1:0]    rd_addr;
   logic                rd_en;
   logic [CNT_W-1:0]    fsp_m1;
   logic                use_stack;
   logic [SLOT_W-1:0]   new_slot;
   logic                at_head;
   logic                head_null;
   logic                prev_valid;
   logic                next_valid;
   logic [CNT_W+COUNT_W-1:0] count_ext;

   logic                nxt_we;
   logic [SLOT_W-1:0]   nxt_wa;
   logic [IDX_W-1:0]    nxt_wd;
   logic                prv_we;
   logic [SLOT_W-1:0]   prv_wa;
   logic [IDX_W-1:0]    prv_wd;

   assign at_head    = (op_ff == OP_INS_HEAD);
   assign head_null  = (head_ff == NIL);
   assign prev_valid = (prev_rd_ff < NIL);
   assign next_valid = (next_rd_ff < NIL);
   assign fsp_m1     = fsp_ff - CNT_W'(1);
   assign use_stack  = (fsp_ff != '0);
   assign new_slot   = use_stack ? free_rd_ff : hwm_ff[SLOT_W-1:0];
   assign count_ext  = {{COUNT_W{1'b0}}, count_ff};

   // Capture the command fields on transfer
   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         op_ff     <= op_type'(req_user);
         key_ff    <= req_data[KEY_W-1:0];
         tag_ff    <= req_data[KEY_W+TAG_W-1:KEY_W];
         weight_ff <= req_data[KEY_W+TAG_W+WEIGHT_W-1:KEY_W+TAG_W];
      end
   end

   // Walk: read one linked entry per cycle
   assign rd_addr = ctl.walk_head ? head_ff : next_rd_ff;
   assign rd_en   = ctl.walk_head | ctl.walk_next;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         cur_ff     <= rd_addr;
         key_rd_ff  <= key_mem[rd_addr[SLOT_W-1:0]];
         next_rd_ff <= nxt_mem[rd_addr[SLOT_W-1:0]];
         prev_rd_ff <= prv_mem[rd_addr[SLOT_W-1:0]];
      end
   end

   // Free stack: keep the top entry read out, push the slot freed by an unlink
   always_ff @(posedge clock) begin
      free_rd_ff <= free_mem[fsp_m1[SLOT_W-1:0]];
      if (ctl.unlink) begin
         free_mem[fsp_ff[SLOT_W-1:0]] <= cur_ff[SLOT_W-1:0];
      end
   end

   // Store the new entry
   always_ff @(posedge clock) begin
      if (ctl.link_new) begin
         key_mem[new_slot] <= key_ff;
         tag_mem[new_slot] <= tag_ff;
         wgt_mem[new_slot] <= weight_ff;
         slot_ff           <= new_slot;
      end
   end

   // Select the forward link write
   always_comb begin
      nxt_we = 1'b0;
      nxt_wa = new_slot;
      nxt_wd = NIL;
      if (ctl.link_new) begin
         nxt_we = 1'b1;
         nxt_wd = at_head ? head_ff : NIL;
      end else if (ctl.link_nbr) begin
         nxt_we = !head_null && !at_head;
         nxt_wa = tail_ff[SLOT_W-1:0];
         nxt_wd = IDX_W'(slot_ff);
      end else if (ctl.unlink) begin
         nxt_we = prev_valid;
         nxt_wa = prev_rd_ff[SLOT_W-1:0];
         nxt_wd = next_rd_ff;
      end
   end

   // Select the backward link write
   always_comb begin
      prv_we = 1'b0;
      prv_wa = new_slot;
      prv_wd = NIL;
      if (ctl.link_new) begin
         prv_we = 1'b1;
         prv_wd = at_head ? NIL : tail_ff;
      end else if (ctl.link_nbr) begin
         prv_we = !head_null && at_head;
         prv_wa = head_ff[SLOT_W-1:0];
         prv_wd = IDX_W'(slot_ff);
      end else if (ctl.unlink) begin
         prv_we = next_valid;
         prv_wa = next_rd_ff[SLOT_W-1:0];
         prv_wd = prev_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (nxt_we) begin
         nxt_mem[nxt_wa] <= nxt_wd;
      end
      if (prv_we) begin
         prv_mem[prv_wa] <= prv_wd;
      end
   end

   // Update head, tail, count and slot allocation
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      fsp_in   = fsp_ff;
      hwm_in   = hwm_ff;
      if (ctl.link_new) begin
         if (use_stack) begin
            fsp_in = fsp_m1;
         end else begin
            hwm_in = hwm_ff + CNT_W'(1);
         end
      end
      if (ctl.link_nbr) begin
         count_in = count_ff + CNT_W'(1);
         if (head_null) begin
            head_in = IDX_W'(slot_ff);
            tail_in = IDX_W'(slot_ff);
         end else if (at_head) begin
            head_in = IDX_W'(slot_ff);
         end else begin
            tail_in = IDX_W'(slot_ff);
         end
      end
      if (ctl.unlink) begin
         fsp_in = fsp_ff + CNT_W'(1);
         if (count_ff != '0) begin
            count_in = count_ff - CNT_W'(1);
         end
         if (!prev_valid) begin
            head_in = next_rd_ff;
         end
         if (!next_valid) begin
            tail_in = prev_rd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= NIL;
         tail_ff  <= NIL;
         count_ff <= '0;
         fsp_ff   <= '0;
         hwm_ff   <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         fsp_ff   <= fsp_in;
         hwm_ff   <= hwm_in;
      end
   end

   // Hold the status of the item in work
   always_ff @(posedge clock) begin
      if (ctl.status_load) begin
         status_ff <= ctl.status_code;
      end
   end

   // Output register: load the result, drop it once transferred
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_count_ff  <= count_ext[COUNT_W-1:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-COUNT_W){1'b0}}, rsp_count_ff};

   // Status to the controller
   assign stat.op         = op_ff;
   assign stat.list_empty = head_null;
   assign stat.key_hit    = (key_rd_ff == key_ff);
   assign stat.next_null  = !next_valid;
   assign stat.table_full = (count_ff == CNT_W'(CAPACITY));
   assign stat.out_free   = !rsp_valid_ff || rsp_tready;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_free_stack: assert property (@(posedge clock) disable iff (reset)
      fsp_ff <= hwm_ff)
      else $error("free stack deeper than slots ever handed out");

   a_empty_match: assert property (@(posedge clock) disable iff (reset)
      ((head_ff == NIL) == (count_ff == '0)) && ((head_ff == NIL) == (tail_ff == NIL)))
      else $error("head, tail and count disagree on an empty list");

   a_link_head: assert property (@(posedge clock) disable iff (reset)
      ctl.link_nbr |=> (head_ff != NIL) && (count_ff != '0))
      else $error("list empty after an insert");

endmodule

[rtl/ukolt_controller.sv]
module ukolt_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  ukolt_pkg::dp_stat_type stat,
   output ukolt_pkg::ctl_cmd_type ctl
);
   import ukolt_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_START  = 7'b0000010,
      S_WALK   = 7'b0000100,
      S_UNLINK = 7'b0001000,
      S_LINK1  = 7'b0010000,
      S_LINK2  = 7'b0100000,
      S_RESP   = 7'b1000000
   } state_type;

   state_type  state_ff, state_in;
   state_type  hit_state, miss_state;
   status_type hit_code, miss_code;

   // Outcome when the walk finds the key
   always_comb begin
      unique case (stat.op)
         OP_REMOVE: begin
            hit_state = S_UNLINK;
            hit_code  = ST_DONE;
         end
         OP_FIND: begin
            hit_state = S_RESP;
            hit_code  = ST_DONE;
         end
         default: begin
            hit_state = S_RESP;
            hit_code  = ST_DUP;
         end
      endcase
   end

   // Outcome when the walk ends without the key
   always_comb begin
      priority if (stat.op == OP_FIND || stat.op == OP_REMOVE) begin
         miss_state = S_RESP;
         miss_code  = ST_MISSING;
      end else if (stat.table_full) begin
         miss_state = S_RESP;
         miss_code  = ST_FULL;
      end else begin
         miss_state = S_LINK1;
         miss_code  = ST_DONE;
      end
   end

   // Sequence one command at a time
   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               ctl.capture = 1'b1;
               state_in    = S_START;
            end
         end
         S_START: begin
            if (stat.list_empty) begin
               ctl.status_load = 1'b1;
               ctl.status_code = miss_code;
               state_in        = miss_state;
            end else begin
               ctl.walk_head = 1'b1;
               state_in      = S_WALK;
            end
         end
         S_WALK: begin
            priority if (stat.key_hit) begin
               ctl.status_load = 1'b1;
               ctl.status_code = hit_code;
               state_in        = hit_state;
            end else if (stat.next_null) begin
               ctl.status_load = 1'b1;
               ctl.status_code = miss_code;
               state_in        = miss_state;
            end else begin
               ctl.walk_next = 1'b1;
            end
         end
         S_UNLINK: begin
            ctl.unlink = 1'b1;
            state_in   = S_RESP;
         end
         S_LINK1: begin
            ctl.link_new = 1'b1;
            state_in     = S_LINK2;
         end
         S_LINK2: begin
            ctl.link_nbr = 1'b1;
            state_in     = S_RESP;
         end
         S_RESP: begin
            if (stat.out_free) begin
               ctl.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

endmodule

[rtl/unique_key_ordered_list_table.sv]
// Ordered table of unique-key entries held as a doubly linked list.
// Commands arrive on the req_ stream: tuser carries the command (insert at
// tail, insert at head, find, remove), tdata the key, name tag and weight.
// Every command gives one transfer on the rsp_ stream: tuser holds the
// status (done, duplicate, missing, full), tdata the entry count after it.
// One command is in work at a time. From the request transfer the block
// passes a start state, walks a non-empty list from the head, reading one
// linked entry a cycle from the key and link memories and comparing its
// key, then passes the link states for an insert or the unlink state for a
// remove, and loads the result register; the next request is taken once
// the block is back in its idle state.
// The result register decouples the two streams: a command is accepted
// while the previous result still waits; a stalled receiver holds the block
// only when the next result is ready to be loaded.
// Reset empties the list at once (head and tail null, count zero, no slot
// handed out); the entry memories need no clearing.
module unique_key_ordered_list_table #(
   parameter int CAPACITY = ukolt_pkg::CAPACITY_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // entry_key [31:0], name_tag [63:32], weight [87:64]
   input  logic [ukolt_pkg::REQ_DATA_W-1:0]  req_tdata,
   // cmd [1:0]
   input  logic [ukolt_pkg::CMD_W-1:0]       req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // entry_count [6:0], zero [7]
   output logic [ukolt_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // status [1:0]
   output logic [ukolt_pkg::STATUS_W-1:0]    rsp_tuser
);
   import ukolt_pkg::*;

   ctl_cmd_type ctl;
   dp_stat_type stat;

   ukolt_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .ctl        (ctl)
   );

   ukolt_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_tdata),
      .req_user   (req_tuser),
      .ctl        (ctl),
      .stat       (stat),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

[tb/sv/tb.sv]
module tb;
   import ukolt_pkg::*;

   localparam int CAP        = CAPACITY_DEF;
   localparam int IDLE_LIMIT = 4000;
   localparam int POOL_N     = 96;

   // Tracks the linked table as commands are accepted and queues the status
   // and count that each command must produce.
   class list_scoreboard;
      localparam int DEPTH = ukolt_pkg::CAPACITY_DEF;

      typedef struct {
         status_type  status;
         logic [6:0]  count;
      } outcome_type;

      logic [31:0] key_mem  [DEPTH];
      logic [31:0] tag_mem  [DEPTH];
      logic [23:0] wgt_mem  [DEPTH];
      int          next_mem [DEPTH];
      int          prev_mem [DEPTH];
      bit          used_mem [DEPTH];
      int          head;
      int          tail;
      int          count;
      int          errors;
      outcome_type want_q [$];

      function new();
         foreach (used_mem[i]) used_mem[i] = 1'b0;
         head   = DEPTH;
         tail   = DEPTH;
         count  = 0;
         errors = 0;
      endfunction

      // Walk from the head; DEPTH means the key is not linked.
      function int locate(logic [31:0] key);
         int cur;
         int steps;
         cur   = head;
         steps = 0;
         while (cur < DEPTH && steps < DEPTH) begin
            if (key_mem[cur] == key) return cur;
            cur = next_mem[cur];
            steps++;
         end
         return DEPTH;
      endfunction

      function int lowest_free();
         for (int i = 0; i < DEPTH; i++)
            if (!used_mem[i]) return i;
         return DEPTH;
      endfunction

      function status_type insert_entry(bit at_head, logic [31:0] key, logic [31:0] tag,
                                        logic [23:0] wgt);
         int s;
         if (locate(key) != DEPTH) return ST_DUP;
         s = lowest_free();
         if (count >= DEPTH || s == DEPTH) return ST_FULL;
         key_mem[s]  = key;
         tag_mem[s]  = tag;
         wgt_mem[s]  = wgt;
         used_mem[s] = 1'b1;
         if (head == DEPTH) begin
            next_mem[s] = DEPTH;
            prev_mem[s] = DEPTH;
            head = s;
            tail = s;
         end else if (at_head) begin
            prev_mem[s]    = DEPTH;
            next_mem[s]    = head;
            prev_mem[head] = s;
            head = s;
         end else begin
            next_mem[s]    = DEPTH;
            prev_mem[s]    = tail;
            next_mem[tail] = s;
            tail = s;
         end
         count++;
         return ST_DONE;
      endfunction

      function status_type remove_entry(logic [31:0] key);
         int s;
         int p;
         int n;
         s = locate(key);
         if (s == DEPTH) return ST_MISSING;
         p = prev_mem[s];
         n = next_mem[s];
         if (p < DEPTH) next_mem[p] = n;
         else head = n;
         if (n < DEPTH) prev_mem[n] = p;
         else tail = p;
         used_mem[s] = 1'b0;
         if (count > 0) count--;
         return ST_DONE;
      endfunction

      // Apply one accepted command and queue its outcome.
      function void note_command(op_type op, logic [31:0] key, logic [31:0] tag,
                                 logic [23:0] wgt);
         outcome_type o;
         case (op)
            OP_INS_TAIL: o.status = insert_entry(1'b0, key, tag, wgt);
            OP_INS_HEAD: o.status = insert_entry(1'b1, key, tag, wgt);
            OP_FIND:     o.status = (locate(key) != DEPTH) ? ST_DONE : ST_MISSING;
            default:     o.status = remove_entry(key);
         endcase
         o.count = 7'(count);
         want_q.push_back(o);
      endfunction

      function int pending();
         return want_q.size();
      endfunction

      task report(string msg);
         errors++;
         if (errors <= 40) $display("ERROR @%0t: %s", $time, msg);
      endtask

      // Compare one result transfer with the oldest outcome.
      task check_result(logic [1:0] status, logic [7:0] data);
         outcome_type o;
         if (want_q.size() == 0) begin
            report($sformatf("unexpected result: status %0d count %0d", status, data[6:0]));
            return;
         end
         o = want_q.pop_front();
         if (status !== o.status)
            report($sformatf("status %0d, want %s", status, o.status.name()));
         if (data[6:0] !== o.count)
            report($sformatf("entry count %0d, want %0d", data[6:0], o.count));
         if (data[7] !== 1'b0)
            report("padding bit of rsp_tdata is not zero");
      endtask
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [CMD_W-1:0]      req_tuser  = OP_FIND;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;

   list_scoreboard sb = new();
   logic [31:0]    key_pool [POOL_N];
   bit             quiet = 1'b0;
   int             stall_left = 0;
   int             idle_cycles = 0;

   unique_key_ordered_list_table #(
      .CAPACITY (CAP)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   // Idle length: mostly short, now and then long.
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Check result transfers and stall the result side at random.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tuser, rsp_tdata);
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else if (!quiet && $urandom_range(0, 99) < 30) begin
         rsp_tready <= 1'b0;
         stall_left = idle_len() - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // End the run when no transfer happens for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // Present one command after an optional gap and hold it until accepted.
   task automatic send_cmd(op_type op, logic [31:0] key, logic [31:0] tag, logic [23:0] wgt);
      int gap;
      gap = (!quiet && $urandom_range(0, 99) < 40) ? idle_len() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {wgt, tag, key};
      do @(posedge clock); while (!req_tready);
      sb.note_command(op, key, tag, wgt);
   endtask

   // Stop sending and wait until every outstanding result has arrived.
   task automatic wait_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // Random commands over the first span keys of the pool, with some noise keys.
   task automatic run_mixed(int n, int span);
      op_type      op;
      logic [31:0] key;
      for (int i = 0; i < n; i++) begin
         op  = op_type'($urandom_range(0, 3));
         key = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, span - 1)];
         send_cmd(op, key, $urandom, 24'($urandom));
      end
   endtask

   initial begin
      op_type      op;
      logic [31:0] key;

      foreach (key_pool[i]) key_pool[i] = $urandom;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Empty table: find and remove miss.
      send_cmd(OP_FIND,     32'h0000_0000, 32'h0, 24'h0);
      send_cmd(OP_REMOVE,   32'hFFFF_FFFF, 32'h0, 24'h0);
      // Extremes of every field, both insert ends.
      send_cmd(OP_INS_TAIL, 32'h0000_0000, 32'h0000_0000, 24'h00_0000);
      send_cmd(OP_INS_HEAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF);
      send_cmd(OP_INS_TAIL, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 24'h80_0000);
      send_cmd(OP_INS_HEAD, 32'h0000_0001, 32'h1234_5678, 24'h00_0100);
      // Duplicates at either end leave the table alone.
      send_cmd(OP_INS_TAIL, 32'h0000_0000, 32'hDEAD_BEEF, 24'h12_3456);
      send_cmd(OP_INS_HEAD, 32'hFFFF_FFFF, 32'h0, 24'h0);
      send_cmd(OP_FIND,     32'h0000_0000, 32'h0, 24'h0);
      send_cmd(OP_FIND,     32'hFFFF_FFFF, 32'h0, 24'h0);
      send_cmd(OP_FIND,     32'h1234_5678, 32'h0, 24'h0);
      // Remove tail, head, then a middle entry.
      send_cmd(OP_REMOVE,   32'h5A5A_5A5A, 32'h0, 24'h0);
      send_cmd(OP_REMOVE,   32'h0000_0001, 32'h0, 24'h0);
      send_cmd(OP_INS_TAIL, 32'h0000_0007, 32'h7777_7777, 24'h00_0007);
      send_cmd(OP_REMOVE,   32'h0000_0000, 32'h0, 24'h0);
      send_cmd(OP_FIND,     32'h0000_0000, 32'h0, 24'h0);
      // Empty the table, remove again, then refill from the head.
      send_cmd(OP_REMOVE,   32'hFFFF_FFFF, 32'h0, 24'h0);
      send_cmd(OP_REMOVE,   32'h0000_0007, 32'h0, 24'h0);
      send_cmd(OP_REMOVE,   32'h0000_0007, 32'h0, 24'h0);
      send_cmd(OP_INS_HEAD, 32'h0000_0009, 32'h0000_0009, 24'h00_0009);
      send_cmd(OP_FIND,     32'h0000_0009, 32'h0, 24'h0);
      send_cmd(OP_REMOVE,   32'h0000_0009, 32'h0, 24'h0);
      wait_results();

      // Fill toward full from both ends, with a duplicate now and then.
      for (int i = 0; i < 80; i++) begin
         op  = ($urandom_range(0, 1) == 1) ? OP_INS_HEAD : OP_INS_TAIL;
         key = (i > 0 && $urandom_range(0, 7) == 0) ? key_pool[$urandom_range(0, i - 1)]
                                                     : key_pool[i];
         send_cmd(op, key, $urandom, 24'($urandom));
      end

      // Churn near full, where new keys hit the full case.
      run_mixed(130, POOL_N);
      wait_results();

      // Drain every pool key, from whatever position it holds.
      for (int i = 0; i < POOL_N; i++) begin
         if ($urandom_range(0, 4) == 0)
            send_cmd(OP_FIND, key_pool[$urandom_range(0, POOL_N - 1)], $urandom,
                     24'($urandom));
         send_cmd(OP_REMOVE, key_pool[i], $urandom, 24'($urandom));
      end

      // Dense reuse of a few keys, first with idling, then back to back.
      run_mixed(100, 16);
      quiet = 1'b1;
      run_mixed(100, 16);
      quiet = 1'b0;

      wait_results();
      repeat (80) @(posedge clock);
      if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
      if (sb.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

[unique_key_ordered_list_table.f]
rtl/ukolt_pkg.sv
rtl/ukolt_datapath.sv
rtl/ukolt_controller.sv
rtl/unique_key_ordered_list_table.sv
tb/sv/tb.sv
